// File: hw/rtl/lcs_pkg.sv
package lcs_pkg;

    localparam int MAX_LINES  = 1024;
    localparam int LINE_IDX_W = $clog2(MAX_LINES);
    localparam int LINE_CNT_W = $clog2(MAX_LINES + 1);
    localparam int INDEX_BITS = 20;

    localparam int CHAR_W  = 16;
    localparam int QUERY_W = 21;
    localparam int LINE_W  = 11;
    localparam int COL_W   = 21;

    localparam logic [CHAR_W-1:0]     SLASH_CH   = 16'h002F;
    localparam logic [CHAR_W-1:0]     NEWLINE_CH = 16'h000A;
    localparam logic [INDEX_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [LINE_CNT_W-1:0] LINES_FULL = LINE_CNT_W'(MAX_LINES);

    localparam logic ACT_CHAR    = 1'b0;
    localparam logic ACT_QUERY   = 1'b1;
    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT0,
        ST_EMIT1,
        ST_PROBE,
        ST_COMPARE,
        ST_COLUMN,
        ST_ANSWER
    } state_t;

endpackage

// File: hw/rtl/lcs_ram.sv
module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/line_comment_stripper_with_position_map_core.sv
// Channel  | Handshake           | Fields
// ---------+---------------------+--------------------------------------------
// in       | in_valid/in_stall   | action, char_code, is_last, query_index
// out      | out_valid/out_stall | out_kind, out_char, out_last, line, column,
//          |                     | overflow
//
// A character item is decoded in its accept cycle; its 0, 1 or 2 results leave one
// per cycle after it while out_stall is low. A query binary-searches the line end
// table, each step a probe then a compare state on the shared subtract unit and
// registered read port; a negative index or empty table goes straight to the answer.
// Reset (rst_n, async, active low) clears control state, not the search/result regs
// or the table. in_stall stays high until the item's last result is taken.
module line_comment_stripper_with_position_map_core
    import lcs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    action,
    input  logic [CHAR_W-1:0]       char_code,
    input  logic                    is_last,
    input  logic signed [QUERY_W-1:0] query_index,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    out_kind,
    output logic [CHAR_W-1:0]       out_char,
    output logic                    out_last,
    output logic signed [LINE_W-1:0] line,
    output logic signed [COL_W-1:0] column,
    output logic                    overflow
);

    state_t                 state_reg, state_next;
    logic [INDEX_BITS-1:0]  emitted_reg, emitted_next;
    logic [LINE_CNT_W-1:0]  line_count_reg, line_count_next;
    logic                   slash_pending_reg, slash_pending_next;
    logic                   inside_comment_reg, inside_comment_next;
    logic                   text_open_reg, text_open_next;
    logic                   saturated_reg, saturated_next;

    logic [LINE_CNT_W-1:0]  lo_reg, lo_next;
    logic [LINE_CNT_W-1:0]  hi_reg, hi_next;
    logic [LINE_CNT_W-1:0]  mid_reg, mid_next;
    logic [INDEX_BITS-1:0]  raw_reg, raw_next;
    logic [CHAR_W-1:0]      char0_reg, char0_next;
    logic [CHAR_W-1:0]      char1_reg, char1_next;
    logic                   two_reg, two_next;
    logic [LINE_W-1:0]      line_reg, line_next;
    logic [COL_W-1:0]       column_reg, column_next;

    logic                   ram_wr_en;
    logic [LINE_IDX_W-1:0]  ram_wr_addr;
    logic                   ram_rd_en;
    logic [LINE_IDX_W-1:0]  ram_rd_addr;
    logic [INDEX_BITS-1:0]  ram_rd_data;

    logic                   accept;
    logic [INDEX_BITS-1:0]  cnt0, cnt1, cnt2;
    logic [LINE_CNT_W-1:0]  lc0;
    logic                   sp0, ic0, sat0, sat1, sat2;
    logic                   is_nl, is_sl;
    logic                   emit_slash, keep, sp1, ic1, tail_slash, record;
    logic [1:0]             emit_n;
    logic                   inc1, inc2;
    logic [LINE_CNT_W:0]    mid_sum;
    logic [LINE_CNT_W-1:0]  lo_dec;
    logic [INDEX_BITS:0]    diff;
    logic                   entry_gt;

    lcs_ram #(
        .WIDTH(INDEX_BITS),
        .DEPTH(MAX_LINES)
    ) u_line_end_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(cnt2),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign accept = in_valid && !in_stall;

    // Shared subtract unit: compare against the probe entry, or form the column.
    assign diff     = {1'b0, raw_reg} - {1'b0, ram_rd_data};
    assign entry_gt = diff[INDEX_BITS];
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign lo_dec   = lo_reg - LINE_CNT_W'(1);

    // Character decode; a new text starts from cleared state.
    always_comb
    begin
        cnt0  = text_open_reg ? emitted_reg : '0;
        lc0   = text_open_reg ? line_count_reg : '0;
        sp0   = text_open_reg && slash_pending_reg;
        ic0   = text_open_reg && inside_comment_reg;
        sat0  = text_open_reg && saturated_reg;
        is_nl = (char_code == NEWLINE_CH);
        is_sl = (char_code == SLASH_CH);

        emit_slash = 1'b0;
        keep       = 1'b0;
        sp1        = 1'b0;
        ic1        = 1'b0;
        priority if (ic0)
        begin
            keep = is_nl;
            ic1  = !is_nl;
        end
        else if (sp0)
        begin
            ic1        = is_sl;
            emit_slash = !is_sl;
            keep       = !is_sl;
        end
        else if (is_sl)
        begin
            sp1 = 1'b1;
        end
        else
        begin
            keep = 1'b1;
        end

        tail_slash = is_last && sp1;
        record     = (keep && is_nl) || (is_last && !is_nl);
        emit_n     = {1'b0, emit_slash} + {1'b0, keep} + {1'b0, tail_slash};

        inc1 = (emit_n != 2'd0);
        inc2 = (emit_n == 2'd2);
        cnt1 = (inc1 && cnt0 != COUNT_MAX) ? cnt0 + INDEX_BITS'(1) : cnt0;
        sat1 = sat0 || (inc1 && cnt0 == COUNT_MAX);
        cnt2 = (inc2 && cnt1 != COUNT_MAX) ? cnt1 + INDEX_BITS'(1) : cnt1;
        sat2 = sat1 || (inc2 && cnt1 == COUNT_MAX) || (record && lc0 == LINES_FULL);
    end

    assign ram_wr_addr = lc0[LINE_IDX_W-1:0];

    always_comb
    begin
        state_next          = state_reg;
        emitted_next        = emitted_reg;
        line_count_next     = line_count_reg;
        slash_pending_next  = slash_pending_reg;
        inside_comment_next = inside_comment_reg;
        text_open_next      = text_open_reg;
        saturated_next      = saturated_reg;
        lo_next             = lo_reg;
        hi_next             = hi_reg;
        mid_next            = mid_reg;
        raw_next            = raw_reg;
        char0_next          = char0_reg;
        char1_next          = char1_reg;
        two_next            = two_reg;
        line_next           = line_reg;
        column_next         = column_reg;
        ram_wr_en           = 1'b0;
        ram_rd_en           = 1'b0;
        ram_rd_addr         = mid_sum[LINE_IDX_W:1];
        in_stall            = (state_reg != ST_IDLE);
        out_valid           = 1'b0;
        out_last            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && action == ACT_CHAR)
                begin
                    emitted_next        = cnt2;
                    slash_pending_next  = sp1 && !is_last;
                    inside_comment_next = ic1 && !is_last;
                    text_open_next      = !is_last;
                    saturated_next      = sat2;
                    line_count_next     = lc0;
                    if (record && lc0 != LINES_FULL)
                    begin
                        ram_wr_en       = 1'b1;
                        line_count_next = lc0 + LINE_CNT_W'(1);
                    end
                    char0_next = (keep && !emit_slash) ? char_code : SLASH_CH;
                    char1_next = emit_slash ? char_code : SLASH_CH;
                    two_next   = inc2;
                    if (inc1)
                    begin
                        state_next = ST_EMIT0;
                    end
                end
                else if (accept)
                begin
                    raw_next = query_index[INDEX_BITS-1:0];
                    lo_next  = '0;
                    hi_next  = line_count_reg;
                    if (query_index[QUERY_W-1] || line_count_reg == '0)
                    begin
                        line_next   = '1;
                        column_next = '1;
                        state_next  = ST_ANSWER;
                    end
                    else
                    begin
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_EMIT0:
            begin
                out_valid = 1'b1;
                out_last  = !two_reg;
                if (!out_stall)
                begin
                    state_next = two_reg ? ST_EMIT1 : ST_IDLE;
                end
            end
            ST_EMIT1:
            begin
                out_valid = 1'b1;
                out_last  = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PROBE:
            begin
                priority if (lo_reg < hi_reg)
                begin
                    ram_rd_en  = 1'b1;
                    mid_next   = mid_sum[LINE_CNT_W:1];
                    state_next = ST_COMPARE;
                end
                else if (lo_reg == line_count_reg)
                begin
                    line_next   = '1;
                    column_next = '1;
                    state_next  = ST_ANSWER;
                end
                else if (lo_reg == '0)
                begin
                    line_next   = '0;
                    column_next = {1'b0, raw_reg};
                    state_next  = ST_ANSWER;
                end
                else
                begin
                    // Fetch the previous line's end to form the column.
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = lo_dec[LINE_IDX_W-1:0];
                    state_next  = ST_COLUMN;
                end
            end
            ST_COMPARE:
            begin
                if (entry_gt)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + LINE_CNT_W'(1);
                end
                state_next = ST_PROBE;
            end
            ST_COLUMN:
            begin
                line_next   = LINE_W'(lo_reg);
                column_next = {1'b0, diff[INDEX_BITS-1:0]};
                state_next  = ST_ANSWER;
            end
            ST_ANSWER:
            begin
                out_valid = 1'b1;
                out_last  = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_kind = (state_reg == ST_ANSWER) ? KIND_ANSWER : KIND_CHAR;
    assign out_char = (state_reg == ST_EMIT1) ? char1_reg
                    : ((state_reg == ST_EMIT0) ? char0_reg : '0);
    assign line     = (state_reg == ST_ANSWER) ? line_reg : '0;
    assign column   = (state_reg == ST_ANSWER) ? column_reg : '0;
    assign overflow = saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            emitted_reg        <= '0;
            line_count_reg     <= '0;
            slash_pending_reg  <= 1'b0;
            inside_comment_reg <= 1'b0;
            text_open_reg      <= 1'b0;
            saturated_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            emitted_reg        <= emitted_next;
            line_count_reg     <= line_count_next;
            slash_pending_reg  <= slash_pending_next;
            inside_comment_reg <= inside_comment_next;
            text_open_reg      <= text_open_next;
            saturated_reg      <= saturated_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        raw_reg    <= raw_next;
        char0_reg  <= char0_next;
        char1_reg  <= char1_next;
        two_reg    <= two_next;
        line_reg   <= line_next;
        column_reg <= column_next;
    end

endmodule

// File: hw/rtl/lcs_checker.sv
module lcs_checker
    import lcs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     action,
    input logic [CHAR_W-1:0]        char_code,
    input logic                     is_last,
    input logic signed [QUERY_W-1:0] query_index,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic                     out_kind,
    input logic [CHAR_W-1:0]        out_char,
    input logic                     out_last,
    input logic signed [LINE_W-1:0] line,
    input logic signed [COL_W-1:0]  column,
    input logic                     overflow
);

    // A query always keeps the block busy for at least the next cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action == ACT_QUERY |=> in_stall)
        else $error("query accepted but block not busy next cycle");

    a_busy_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("new item accepted while a result is pending");

    a_answer_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_ANSWER |-> out_last)
        else $error("query answer not marked last");

    a_answer_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_ANSWER |->
            ((line == '1) == (column == '1)))
        else $error("line and column disagree on not-found");

    a_char_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_CHAR |-> line == '0 && column == '0)
        else $error("character result carries a position");

endmodule

bind line_comment_stripper_with_position_map_core lcs_checker u_lcs_checker (.*);
